@@ rtl/core/rspr_pkg.sv @@
// ----------------------------------------------------------------------------
// rspr_pkg - shared types and constants for the RSP packet receiver
// Character codes, result kinds, controller states, command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package rspr_pkg;

   localparam int BUFFER_BYTES_DEF = 32;

   // framing characters
   localparam logic [7:0] CHAR_START = 8'h24;   // '$'
   localparam logic [7:0] CHAR_HASH  = 8'h23;   // '#'
   localparam logic [7:0] CHAR_COLON = 8'h3A;   // ':'
   localparam logic [7:0] CHAR_ACK   = 8'h2B;   // '+'
   localparam logic [7:0] CHAR_NAK   = 8'h2D;   // '-'

   // result kinds
   localparam logic [1:0] KIND_HOST    = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_EMPTY   = 2'd2;

   // id bytes ahead of the payload
   localparam int ID_SKIP = 3;

   typedef enum logic [3:0] {
      ST_HUNT,
      ST_BODY,
      ST_HI,
      ST_LO,
      ST_NAK,
      ST_ACK,
      ST_ID0,
      ST_ID1,
      ST_RD,
      ST_PAY,
      ST_EMPTY
   } ctl_state_type;

   typedef enum logic [2:0] {
      OSEL_NAK,
      OSEL_ACK,
      OSEL_ID0,
      OSEL_ID1,
      OSEL_PAY,
      OSEL_EMPTY
   } out_sel_type;

   typedef struct packed {
      logic        start_body;
      logic        store_byte;
      logic        latch_high;
      logic        ptr_init;
      logic        ptr_inc;
      logic        load_out;
      out_sel_type out_sel;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_start;
      logic is_hash;
      logic body_full;
      logic check_pass;
      logic has_id;
      logic no_payload;
      logic pay_last;
      logic out_free;
   } dp_status_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type res;
      res.ok  = 1'b0;
      res.val = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         res.ok  = 1'b1;
         res.val = c[3:0];
      end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         res.ok  = 1'b1;
         res.val = 4'(c[3:0] + 4'd9);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/rspr_ctrl.sv @@
// ----------------------------------------------------------------------------
// rspr_ctrl - packet receiver controller
// Tracks the framing phase and sequences the result run after a checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module rspr_ctrl
   import rspr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output ctl_cmd_type        cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;
   logic          accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.out_sel   = OSEL_NAK;
      req_ready     = state_ff inside {ST_HUNT, ST_BODY, ST_HI, ST_LO};
      accept        = req_valid & req_ready;

      case (state_ff)
         ST_HUNT: begin
            if (accept && status.is_start) begin
               cmd.start_body = 1'b1;
               state_in       = ST_BODY;
            end
         end
         ST_BODY: begin
            if (accept) begin
               if (status.is_start) begin
                  cmd.start_body = 1'b1;
               end else if (status.is_hash) begin
                  state_in = ST_HI;
               end else begin
                  cmd.store_byte = 1'b1;
                  if (status.body_full) begin
                     state_in = ST_HUNT;   // overflow: drop silently
                  end
               end
            end
         end
         ST_HI: begin
            if (accept) begin
               cmd.latch_high = 1'b1;
               state_in       = ST_LO;
            end
         end
         ST_LO: begin
            if (accept) begin
               state_in = status.check_pass ? ST_ACK : ST_NAK;
            end
         end
         ST_NAK: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_sel  = OSEL_NAK;
               state_in     = ST_HUNT;
            end
         end
         ST_ACK: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_sel  = OSEL_ACK;
               cmd.ptr_init = 1'b1;
               if (status.has_id) begin
                  state_in = ST_ID0;
               end else if (status.no_payload) begin
                  state_in = ST_EMPTY;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_ID0: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_sel  = OSEL_ID0;
               state_in     = ST_ID1;
            end
         end
         ST_ID1: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_sel  = OSEL_ID1;
               state_in     = status.no_payload ? ST_EMPTY : ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_PAY;   // store read in flight
         end
         ST_PAY: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_sel  = OSEL_PAY;
               cmd.ptr_inc  = 1'b1;
               state_in     = status.pay_last ? ST_HUNT : ST_RD;
            end
         end
         ST_EMPTY: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_sel  = OSEL_EMPTY;
               state_in     = ST_HUNT;
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/rspr_datapath.sv @@
// ----------------------------------------------------------------------------
// rspr_datapath - packet receiver datapath
// Body store, running sum, checksum compare, id capture and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rspr_datapath
   import rspr_pkg::*;
#(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [7:0]  req_rx_byte,
   input  wire ctl_cmd_type cmd,
   output dp_status_type    status,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_result_kind,
   output logic [7:0]       rsp_result_byte,
   output logic             rsp_last_of_run
);

   localparam int CW  = $clog2(BUFFER_BYTES);
   localparam int CW1 = CW + 1;
   localparam logic [CW:0] FULL_MARK = CW1'(BUFFER_BYTES - 1);

   logic [7:0]    store_mem [BUFFER_BYTES];
   logic [7:0]    rd_data_ff;

   logic [7:0]    sum_ff, sum_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [3:0]    high_ff, high_in;
   logic          high_bad_ff, high_bad_in;
   logic [7:0]    id0_ff, id1_ff, id2_ff;

   logic          out_valid_ff, out_valid_in;
   logic [1:0]    kind_ff;
   logic [7:0]    byte_ff;
   logic          last_ff;

   logic [CW:0]   count_next;
   logic [CW:0]   ptr_next;
   hex_type       hex;
   logic          taken;

   assign hex        = hex_decode(req_rx_byte);
   assign count_next = {1'b0, count_ff} + {{CW{1'b0}}, 1'b1};
   assign ptr_next   = {1'b0, ptr_ff} + {{CW{1'b0}}, 1'b1};
   assign taken      = out_valid_ff & ~rsp_stall;

   // status to the controller
   always_comb begin
      status.is_start   = (req_rx_byte == CHAR_START);
      status.is_hash    = (req_rx_byte == CHAR_HASH);
      status.body_full  = (count_next >= FULL_MARK);
      status.check_pass = hex.ok & ~high_bad_ff & ({high_ff, hex.val} == sum_ff);
      status.has_id     = (count_ff >= CW'(ID_SKIP)) && (id2_ff == CHAR_COLON);
      status.no_payload = status.has_id ? (count_ff <= CW'(ID_SKIP))
                                        : (count_ff == '0);
      status.pay_last   = (ptr_next == {1'b0, count_ff});
      status.out_free   = ~out_valid_ff | ~rsp_stall;
   end

   // body accumulation and checksum digit
   always_comb begin
      sum_in      = sum_ff;
      count_in    = count_ff;
      high_in     = high_ff;
      high_bad_in = high_bad_ff;
      ptr_in      = ptr_ff;
      if (cmd.start_body) begin
         sum_in   = 8'd0;
         count_in = '0;
      end else if (cmd.store_byte) begin
         sum_in   = sum_ff + req_rx_byte;
         count_in = count_next[CW-1:0];
      end
      if (cmd.latch_high) begin
         high_in     = hex.val;
         high_bad_in = ~hex.ok;
      end
      if (cmd.ptr_init) begin
         ptr_in = status.has_id ? CW'(ID_SKIP) : '0;
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_next[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= 8'd0;
         count_ff    <= '0;
         high_ff     <= 4'd0;
         high_bad_ff <= 1'b0;
         ptr_ff      <= '0;
      end else begin
         sum_ff      <= sum_in;
         count_ff    <= count_in;
         high_ff     <= high_in;
         high_bad_ff <= high_bad_in;
         ptr_ff      <= ptr_in;
      end
   end

   // body store, one write and one registered read
   always_ff @(posedge clock) begin
      if (cmd.store_byte) begin
         store_mem[count_ff] <= req_rx_byte;
      end
      rd_data_ff <= store_mem[ptr_ff];
   end

   // first three body bytes kept aside for the id check
   always_ff @(posedge clock) begin
      if (cmd.store_byte) begin
         if (count_ff == CW'(0)) id0_ff <= req_rx_byte;
         if (count_ff == CW'(1)) id1_ff <= req_rx_byte;
         if (count_ff == CW'(2)) id2_ff <= req_rx_byte;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (taken) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         case (cmd.out_sel)
            OSEL_NAK: begin
               kind_ff <= KIND_HOST;
               byte_ff <= CHAR_NAK;
               last_ff <= 1'b1;
            end
            OSEL_ACK: begin
               kind_ff <= KIND_HOST;
               byte_ff <= CHAR_ACK;
               last_ff <= 1'b0;
            end
            OSEL_ID0: begin
               kind_ff <= KIND_HOST;
               byte_ff <= id0_ff;
               last_ff <= 1'b0;
            end
            OSEL_ID1: begin
               kind_ff <= KIND_HOST;
               byte_ff <= id1_ff;
               last_ff <= 1'b0;
            end
            OSEL_PAY: begin
               kind_ff <= KIND_PAYLOAD;
               byte_ff <= rd_data_ff;
               last_ff <= status.pay_last;
            end
            OSEL_EMPTY: begin
               kind_ff <= KIND_EMPTY;
               byte_ff <= 8'd0;
               last_ff <= 1'b1;
            end
            default: begin
               kind_ff <= KIND_HOST;
               byte_ff <= CHAR_NAK;
               last_ff <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_result_byte = byte_ff;
   assign rsp_last_of_run = last_ff;

endmodule

`default_nettype wire

@@ rtl/core/rsp_packet_receiver.sv @@
// ----------------------------------------------------------------------------
// rsp_packet_receiver - remote serial protocol packet receive engine
// Frames '$'...'#xx' packets, checks the mod-256 checksum, answers '+'/'-',
// echoes an optional sequence id and streams the payload out.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_valid/req_stall/req_rx_byte): one received byte per
//    request. Bytes outside a packet other than '$' are swallowed.
//  - Response channel (rsp_valid/rsp_stall/...): results in order. Kind 0 is a
//    byte for the host ('+', '-', id chars), kind 1 a payload byte, kind 2 an
//    empty accepted packet. rsp_last_of_run marks the end of each run.
//  - Bytes up to the second checksum digit are taken one per cycle. That digit
//    starts a run: '+'/'-' is loaded into the output reg first; the id bytes
//    follow one per cycle while the output is not stalled, then each payload
//    byte takes a registered read of the body store and then an output load.
//  - req_stall stays high while a run is being emitted; bytes are taken
//    again once the last result of the run is loaded into the output reg.
//  - A stall on rsp_stall holds the output register and the run simply
//    waits; incoming bytes are still taken if no run is in progress.
//  - Reset returns to hunting for '$' and clears the output valid. The body
//    store is not cleared; only bytes of the current packet are read back.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_packet_receiver
   import rspr_pkg::*;
#(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_result_kind,
   output logic [7:0]      rsp_result_byte,
   output logic            rsp_last_of_run
);

   ctl_cmd_type   cmd;
   dp_status_type status;
   logic          req_ready;

   // request side: not ready while a result run is sequenced
   assign req_stall = ~req_ready;

   rspr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rspr_datapath #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_rx_byte     (req_rx_byte),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_result_byte (rsp_result_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

@@ rtl/core/rspr_checker.sv @@
// ----------------------------------------------------------------------------
// rspr_checker - port level checks for the RSP packet receiver
// Watches the response channel over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rspr_checker
   import rspr_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_result_kind,
   input wire logic [7:0] rsp_result_byte,
   input wire logic       rsp_last_of_run
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_result_byte) && $stable(rsp_last_of_run))
      else $error("stalled response changed");

   // empty packet marker is a final, zero result
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_EMPTY |->
         rsp_result_byte == 8'd0 && rsp_last_of_run)
      else $error("malformed empty-packet result");

   // a run in progress keeps the request side closed
   a_run_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> req_stall)
      else $error("request taken mid-run");

   // only the three defined result kinds ever show
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_kind == KIND_HOST
         || rsp_result_kind == KIND_PAYLOAD || rsp_result_kind == KIND_EMPTY)
      else $error("undefined result kind");

   // nothing shows right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind rsp_packet_receiver rspr_checker u_rspr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_result_kind (rsp_result_kind),
   .rsp_result_byte (rsp_result_byte),
   .rsp_last_of_run (rsp_last_of_run)
);

`default_nettype wire
